>>> hdl/tqot_pkg.sv
// Shared codes, widths and result-queue types for the two-sided quote order tracker.
package tqot_pkg;

   localparam int FIELD_BITS = 32;
   localparam int CASH_BITS  = 64;

   localparam int DEF_PRICE_BITS = 32;
   localparam int DEF_QTY_BITS   = 32;
   localparam int DEF_ID_BITS    = 32;

   localparam logic [1:0] OP_UPDATE = 2'd0;
   localparam logic [1:0] OP_ACK    = 2'd1;
   localparam logic [1:0] OP_TRADE  = 2'd2;

   localparam logic [1:0] KIND_SUBMIT = 2'd0;
   localparam logic [1:0] KIND_MODIFY = 2'd1;
   localparam logic [1:0] KIND_CANCEL = 2'd2;
   localparam logic [1:0] KIND_FILL   = 2'd3;

   localparam logic SIDE_BID = 1'b0;
   localparam logic SIDE_ASK = 1'b1;

   localparam logic [CASH_BITS-1:0] CASH_MIN = {1'b1, {(CASH_BITS-1){1'b0}}};
   localparam logic [CASH_BITS-1:0] CASH_MAX = {1'b0, {(CASH_BITS-1){1'b1}}};
   localparam logic [FIELD_BITS-1:0] POS_BIAS = {1'b1, {(FIELD_BITS-1){1'b0}}};

   typedef struct packed {
      logic [1:0]            kind;
      logic                  side;
      logic [FIELD_BITS-1:0] ord_id;
      logic [FIELD_BITS-1:0] price;
      logic [FIELD_BITS-1:0] quantity;
   } rsp_item_type;

   // one executed request: one or two result words sharing position and cash
   typedef struct packed {
      logic                  two;
      rsp_item_type          r0;
      rsp_item_type          r1;
      logic [FIELD_BITS-1:0] inv;
      logic [CASH_BITS-1:0]  cash;
   } rsp_entry_type;

endpackage

>>> hdl/tqot_req_if.sv
// Request channel: valid/ready handshake with the market event word.
interface tqot_req_if import tqot_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [1:0]            opcode;
   logic                  bid_wanted;
   logic [FIELD_BITS-1:0] bid_px;
   logic [FIELD_BITS-1:0] bid_qty;
   logic                  ask_wanted;
   logic [FIELD_BITS-1:0] ask_px;
   logic [FIELD_BITS-1:0] ask_qty;
   logic [FIELD_BITS-1:0] ref_id;
   logic [FIELD_BITS-1:0] amount;
   logic [FIELD_BITS-1:0] trade_price;
   logic [FIELD_BITS-1:0] bid_new_id;
   logic [FIELD_BITS-1:0] ask_new_id;

   modport source (output valid, opcode, bid_wanted, bid_px, bid_qty, ask_wanted,
                   ask_px, ask_qty, ref_id, amount, trade_price, bid_new_id,
                   ask_new_id, input ready);
   modport sink (input valid, opcode, bid_wanted, bid_px, bid_qty, ask_wanted,
                 ask_px, ask_qty, ref_id, amount, trade_price, bid_new_id,
                 ask_new_id, output ready);
endinterface

>>> hdl/tqot_rsp_if.sv
// Response channel: valid/ready handshake with one order action or fill word.
interface tqot_rsp_if import tqot_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic [1:0]                   kind;
   logic                         side;
   logic [FIELD_BITS-1:0]        ord_id;
   logic [FIELD_BITS-1:0]        price;
   logic [FIELD_BITS-1:0]        quantity;
   logic signed [FIELD_BITS-1:0] inv_after;
   logic signed [CASH_BITS-1:0]  cash_after;
   logic                         last;

   modport source (output valid, kind, side, ord_id, price, quantity, inv_after,
                   cash_after, last, input ready);
   modport sink (input valid, kind, side, ord_id, price, quantity, inv_after,
                 cash_after, last, output ready);
endinterface

>>> hdl/two_sided_quote_order_tracker_core.sv
// Two-sided quote order tracker: one resting maker order per side, position and cash.
//
// req_bus carries market event words (quote update, order ack, trade). A word is
// taken when valid and ready are both high. rsp_bus returns order actions
// (submit, modify, cancel) and fill reports; last marks the final word of a request.
// An update yields up to two words (bid first), a matched trade one fill word, an
// ack or an unmatched trade none.
// An accepted word is registered (trade product formed on the way in), then executed
// against the order state into a two-entry result queue once the queue has room (or
// is being popped), and its first result is offered from there.
// Throughput: one request per cycle for acks, trades and single-action updates while
// rsp_bus takes every word; an update acting on both sides is held back by the
// single result port, which returns its two words one after the other.
// Reset (synchronous, active high) clears both orders, position, cash and the queue.
// When rsp_bus stalls, the queue and the execute register fill and req_bus.ready
// drops; nothing is lost or repeated.
module two_sided_quote_order_tracker_core import tqot_pkg::*; #(
   parameter int PRICE_BITS = DEF_PRICE_BITS,
   parameter int QTY_BITS   = DEF_QTY_BITS,
   parameter int ID_BITS    = DEF_ID_BITS
) (
   input  logic  clock,
   input  logic  reset,
   tqot_req_if.sink   req_bus,
   tqot_rsp_if.source rsp_bus
);

   // request register
   logic                  item_valid_ff;
   logic [1:0]            op_ff;
   logic [1:0]            want_ff;
   logic [PRICE_BITS-1:0] dprice_ff [2];
   logic [QTY_BITS-1:0]   dqty_ff [2];
   logic [ID_BITS-1:0]    newid_ff [2];
   logic [ID_BITS-1:0]    ref_ff;
   logic [QTY_BITS-1:0]   amt_ff;
   logic [PRICE_BITS-1:0] tp_ff;
   logic [CASH_BITS-1:0]  prod_ff;

   // order and account state
   logic [ID_BITS-1:0]    oid_ff [2];
   logic [ID_BITS-1:0]    oid_in [2];
   logic [1:0]            pend_ff, pend_in;
   logic [1:0]            rest_ff, rest_in;
   logic [PRICE_BITS-1:0] rprice_ff [2];
   logic [PRICE_BITS-1:0] rprice_in [2];
   logic [QTY_BITS-1:0]   rqty_ff [2];
   logic [QTY_BITS-1:0]   rqty_in [2];
   logic [FIELD_BITS-1:0] net_ff, net_in;
   logic [CASH_BITS-1:0]  cash_ff, cash_in;

   // result queue
   rsp_entry_type q_ff [2];
   logic          head_ff, tail_ff, sub_ff;
   logic [1:0]    count_ff;

   logic [FIELD_BITS-1:0] amt_mul, tp_mul;
   logic                  exec_fire, push, pop, rsp_fire, cur_last;
   rsp_entry_type         ent_in, head_ent;
   rsp_item_type          act [2];
   logic [1:0]            act_v;
   logic                  hit0, hit1, fill_hit, fs;
   logic [QTY_BITS-1:0]   rq_sel, rq_left;
   logic [FIELD_BITS-1:0] size32, biased, new_biased;
   logic [FIELD_BITS:0]   bsum, bdif;
   logic [CASH_BITS-1:0]  room;
   rsp_item_type          fill_item;

   assign pop       = rsp_fire && cur_last;
   assign exec_fire = item_valid_ff && ((count_ff != 2'd2) || pop);
   assign req_bus.ready = !item_valid_ff || exec_fire;

   assign amt_mul = FIELD_BITS'(QTY_BITS'(req_bus.amount));
   assign tp_mul  = FIELD_BITS'(PRICE_BITS'(req_bus.trade_price));

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         item_valid_ff <= req_bus.valid;
      end
      if (req_bus.valid && req_bus.ready) begin
         op_ff        <= req_bus.opcode;
         want_ff      <= {req_bus.ask_wanted, req_bus.bid_wanted};
         dprice_ff[0] <= PRICE_BITS'(req_bus.bid_px);
         dprice_ff[1] <= PRICE_BITS'(req_bus.ask_px);
         dqty_ff[0]   <= QTY_BITS'(req_bus.bid_qty);
         dqty_ff[1]   <= QTY_BITS'(req_bus.ask_qty);
         newid_ff[0]  <= ID_BITS'(req_bus.bid_new_id);
         newid_ff[1]  <= ID_BITS'(req_bus.ask_new_id);
         ref_ff       <= ID_BITS'(req_bus.ref_id);
         amt_ff       <= QTY_BITS'(req_bus.amount);
         tp_ff        <= PRICE_BITS'(req_bus.trade_price);
         prod_ff      <= CASH_BITS'(amt_mul) * CASH_BITS'(tp_mul);
      end
   end

   // trade matching and fill arithmetic; the bid wins when both ids match
   always_comb begin
      hit0     = (oid_ff[0] != '0) && (ref_ff == oid_ff[0]);
      hit1     = (oid_ff[1] != '0) && (ref_ff == oid_ff[1]);
      fill_hit = hit0 || hit1;
      fs       = hit0 ? SIDE_BID : SIDE_ASK;
      rq_sel   = rqty_ff[fs];
      rq_left  = (amt_ff >= rq_sel) ? '0 : rq_sel - amt_ff;
      size32   = FIELD_BITS'(amt_ff);
      biased   = net_ff ^ POS_BIAS;
      bsum     = {1'b0, biased} + {1'b0, size32};
      bdif     = {1'b0, biased} - {1'b0, size32};
      room     = CASH_MAX - cash_ff;
      if (fs == SIDE_BID) begin
         new_biased = bsum[FIELD_BITS] ? '1 : bsum[FIELD_BITS-1:0];
      end else begin
         new_biased = bdif[FIELD_BITS] ? '0 : bdif[FIELD_BITS-1:0];
      end
      fill_item.kind     = KIND_FILL;
      fill_item.side     = fs;
      fill_item.ord_id   = FIELD_BITS'(ref_ff);
      fill_item.price    = FIELD_BITS'(tp_ff);
      fill_item.quantity = FIELD_BITS'(amt_ff);
   end

   always_comb begin
      oid_in    = oid_ff;
      pend_in   = pend_ff;
      rest_in   = rest_ff;
      rprice_in = rprice_ff;
      rqty_in   = rqty_ff;
      net_in    = net_ff;
      cash_in   = cash_ff;
      act_v     = '0;
      for (int s = 0; s < 2; s++) begin
         act[s].kind     = KIND_SUBMIT;
         act[s].side     = s[0];
         act[s].ord_id   = FIELD_BITS'(oid_ff[s]);
         act[s].price    = FIELD_BITS'(dprice_ff[s]);
         act[s].quantity = FIELD_BITS'(dqty_ff[s]);
      end
      push = 1'b0;
      ent_in.two  = 1'b0;
      ent_in.r0   = fill_item;
      ent_in.r1   = fill_item;
      unique case (op_ff)
         OP_UPDATE: begin
            for (int s = 0; s < 2; s++) begin
               if (!pend_ff[s]) begin
                  if (!want_ff[s]) begin
                     if (rest_ff[s]) begin
                        act_v[s]        = 1'b1;
                        act[s].kind     = KIND_CANCEL;
                        act[s].price    = '0;
                        act[s].quantity = '0;
                        rest_in[s]      = 1'b0;
                     end
                  end else if (!rest_ff[s]) begin
                     act_v[s]        = 1'b1;
                     act[s].kind     = KIND_SUBMIT;
                     act[s].ord_id   = FIELD_BITS'(newid_ff[s]);
                     oid_in[s]       = newid_ff[s];
                     pend_in[s]      = 1'b1;
                     rprice_in[s]    = dprice_ff[s];
                     rqty_in[s]      = dqty_ff[s];
                  end else if (rprice_ff[s] != dprice_ff[s] || rqty_ff[s] != dqty_ff[s]) begin
                     act_v[s]     = 1'b1;
                     act[s].kind  = KIND_MODIFY;
                     pend_in[s]   = 1'b1;
                     rprice_in[s] = dprice_ff[s];
                     rqty_in[s]   = dqty_ff[s];
                  end
               end
            end
            push = act_v[0] || act_v[1];
            if (act_v[0]) begin
               ent_in.r0  = act[0];
               ent_in.r1  = act[1];
               ent_in.two = act_v[1];
            end else begin
               ent_in.r0 = act[1];
               ent_in.r1 = act[1];
            end
         end
         OP_ACK: begin
            for (int s = 0; s < 2; s++) begin
               if (oid_ff[s] == ref_ff && pend_ff[s]) begin
                  pend_in[s] = 1'b0;
                  rest_in[s] = (amt_ff != '0);
                  if (amt_ff != '0) begin
                     rqty_in[s] = amt_ff;
                  end
               end
            end
         end
         OP_TRADE: begin
            if (fill_hit) begin
               push        = 1'b1;
               rqty_in[fs] = rq_left;
               if (rq_left == '0) begin
                  rest_in[fs] = 1'b0;
               end
               net_in = new_biased ^ POS_BIAS;
               if (fs == SIDE_BID) begin
                  cash_in = (prod_ff > (cash_ff ^ CASH_MIN)) ? CASH_MIN : cash_ff - prod_ff;
               end else begin
                  cash_in = (prod_ff > room) ? CASH_MAX : cash_ff + prod_ff;
               end
            end
         end
         default: begin
         end
      endcase
      ent_in.inv  = net_in;
      ent_in.cash = cash_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oid_ff    <= '{default: '0};
         pend_ff   <= '0;
         rest_ff   <= '0;
         rprice_ff <= '{default: '0};
         rqty_ff   <= '{default: '0};
         net_ff    <= '0;
         cash_ff   <= '0;
      end else if (exec_fire) begin
         oid_ff    <= oid_in;
         pend_ff   <= pend_in;
         rest_ff   <= rest_in;
         rprice_ff <= rprice_in;
         rqty_ff   <= rqty_in;
         net_ff    <= net_in;
         cash_ff   <= cash_in;
      end
   end

   // result queue: one entry per request that produced words
   always_ff @(posedge clock) begin
      if (exec_fire && push) begin
         q_ff[tail_ff] <= ent_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= 1'b0;
         tail_ff  <= 1'b0;
         sub_ff   <= 1'b0;
         count_ff <= '0;
      end else begin
         if (exec_fire && push) begin
            tail_ff <= !tail_ff;
         end
         if (pop) begin
            head_ff <= !head_ff;
         end
         if (rsp_fire) begin
            sub_ff <= !cur_last;
         end
         count_ff <= count_ff + 2'(exec_fire && push) - 2'(pop);
      end
   end

   assign head_ent = q_ff[head_ff];
   assign cur_last = !head_ent.two || sub_ff;
   assign rsp_fire = rsp_bus.valid && rsp_bus.ready;

   always_comb begin
      rsp_item_type cur;
      cur = sub_ff ? head_ent.r1 : head_ent.r0;
      rsp_bus.valid      = (count_ff != '0);
      rsp_bus.kind       = cur.kind;
      rsp_bus.side       = cur.side;
      rsp_bus.ord_id     = cur.ord_id;
      rsp_bus.price      = cur.price;
      rsp_bus.quantity   = cur.quantity;
      rsp_bus.inv_after  = head_ent.inv;
      rsp_bus.cash_after = head_ent.cash;
      rsp_bus.last       = cur_last;
   end

   // a request is never executed into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (exec_fire && push) |-> (count_ff != 2'd2 || pop))
      else $error("result queue overflow");

   // the second word of an entry is only reached for two-word entries
   a_sub_two: assert property (@(posedge clock) disable iff (reset)
      (sub_ff && count_ff != '0) |-> head_ent.two)
      else $error("second word selected on single-word entry");

   // a fill report is always a request's only word
   a_fill_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.kind == KIND_FILL) |-> (rsp_bus.last && !sub_ff))
      else $error("fill report not a lone last word");

   // draining the last entry with nothing new leaves the channel empty
   a_drain: assert property (@(posedge clock) disable iff (reset)
      (pop && count_ff == 2'd1 && !(exec_fire && push)) |=> !rsp_bus.valid)
      else $error("queue count out of step");

endmodule

>>> dv/tb_two_sided_quote_order_tracker_core.sv
// Self-checking testbench for the two-sided quote order tracker: directed and random words.
module tb_two_sided_quote_order_tracker_core;
   import tqot_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int RANDOM_WORDS = 950;
   localparam int SEGMENT_WORDS = 120;
   localparam int DRAIN_CYCLES = 20;

   typedef struct packed {
      logic [1:0]            opcode;
      logic                  bid_wanted;
      logic [FIELD_BITS-1:0] bid_px;
      logic [FIELD_BITS-1:0] bid_qty;
      logic                  ask_wanted;
      logic [FIELD_BITS-1:0] ask_px;
      logic [FIELD_BITS-1:0] ask_qty;
      logic [FIELD_BITS-1:0] ref_id;
      logic [FIELD_BITS-1:0] amount;
      logic [FIELD_BITS-1:0] trade_price;
      logic [FIELD_BITS-1:0] bid_new_id;
      logic [FIELD_BITS-1:0] ask_new_id;
   } event_word_type;

   typedef struct packed {
      logic [1:0]            kind;
      logic                  side;
      logic [FIELD_BITS-1:0] ord_id;
      logic [FIELD_BITS-1:0] price;
      logic [FIELD_BITS-1:0] quantity;
      logic [FIELD_BITS-1:0] inventory;
      logic [CASH_BITS-1:0]  cash;
      logic                  last;
   } action_word_type;

   typedef enum int {GAP_NONE, GAP_SEND, GAP_RECV, GAP_BOTH} gap_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tqot_req_if req_bus ();
   tqot_rsp_if rsp_bus ();

   event_word_type req_word  = '0;
   logic           req_valid = 1'b0;
   logic           req_taken = 1'b0;
   logic           rsp_ready = 1'b0;

   assign req_bus.valid       = req_valid;
   assign req_bus.opcode      = req_word.opcode;
   assign req_bus.bid_wanted  = req_word.bid_wanted;
   assign req_bus.bid_px      = req_word.bid_px;
   assign req_bus.bid_qty     = req_word.bid_qty;
   assign req_bus.ask_wanted  = req_word.ask_wanted;
   assign req_bus.ask_px      = req_word.ask_px;
   assign req_bus.ask_qty     = req_word.ask_qty;
   assign req_bus.ref_id      = req_word.ref_id;
   assign req_bus.amount      = req_word.amount;
   assign req_bus.trade_price = req_word.trade_price;
   assign req_bus.bid_new_id  = req_word.bid_new_id;
   assign req_bus.ask_new_id  = req_word.ask_new_id;
   assign rsp_bus.ready       = rsp_ready;

   two_sided_quote_order_tracker_core DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // tracker image: one maker order per side, position and cash as raw bits
   logic [FIELD_BITS-1:0] book_id      [2];
   logic                  book_pending [2];
   logic                  book_live    [2];
   logic [FIELD_BITS-1:0] book_price   [2];
   logic [FIELD_BITS-1:0] book_qty     [2];
   logic [FIELD_BITS-1:0] position;
   logic [CASH_BITS-1:0]  cash;

   event_word_type  pending_words [$];
   action_word_type actions_due [$];
   logic [FIELD_BITS-1:0] recent_ids [$];
   gap_mode_type gap_mode = GAP_NONE;

   int mismatches = 0;
   int n_updates = 0;
   int n_acks = 0;
   int n_trades = 0;
   int n_actions = 0;
   int n_fills = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("two_sided_quote_order_tracker_core regression: fail");
      $finish;
   end

   task automatic queue_word(event_word_type w);
      pending_words.insert(pending_words.size(), w);
   endtask

   task automatic post_action(logic [1:0] kind, int s, logic [FIELD_BITS-1:0] id,
                              logic [FIELD_BITS-1:0] px, logic [FIELD_BITS-1:0] qty);
      action_word_type a;
      a.kind      = kind;
      a.side      = (s == 0) ? SIDE_BID : SIDE_ASK;
      a.ord_id    = id;
      a.price     = px;
      a.quantity  = qty;
      a.inventory = position;
      a.cash      = cash;
      a.last      = 1'b0;
      actions_due.insert(actions_due.size(), a);
   endtask

   task automatic requote_side(int s, logic wanted, logic [FIELD_BITS-1:0] px,
                               logic [FIELD_BITS-1:0] qty, logic [FIELD_BITS-1:0] new_id,
                               inout int k);
      if (book_pending[s]) return;
      if (!wanted) begin
         if (book_live[s]) begin
            post_action(KIND_CANCEL, s, book_id[s], '0, '0);
            book_live[s] = 1'b0;
            k++;
         end
      end else if (!book_live[s]) begin
         book_id[s]      = new_id;
         book_pending[s] = 1'b1;
         book_price[s]   = px;
         book_qty[s]     = qty;
         post_action(KIND_SUBMIT, s, new_id, px, qty);
         k++;
      end else if (book_price[s] != px || book_qty[s] != qty) begin
         book_pending[s] = 1'b1;
         book_price[s]   = px;
         book_qty[s]     = qty;
         post_action(KIND_MODIFY, s, book_id[s], px, qty);
         k++;
      end
   endtask

   task automatic ack_side(int s, logic [FIELD_BITS-1:0] id, logic [FIELD_BITS-1:0] qty);
      if (book_id[s] != id || !book_pending[s]) return;
      book_pending[s] = 1'b0;
      if (qty != 0) begin
         book_live[s] = 1'b1;
         book_qty[s]  = qty;
      end else begin
         book_live[s] = 1'b0;
      end
   endtask

   task automatic fill_side(int s, logic [FIELD_BITS-1:0] size, logic [FIELD_BITS-1:0] px);
      logic [63:0] biased;
      logic [63:0] prod;
      logic [63:0] room;
      book_qty[s] = (size >= book_qty[s]) ? '0 : book_qty[s] - size;
      if (book_qty[s] == 0) book_live[s] = 1'b0;
      biased = {32'd0, position ^ POS_BIAS};
      // 32 x 32 product cannot pass 2^64-1
      prod = {32'd0, size} * {32'd0, px};
      if (s == 0) begin
         if ({32'd0, size} > 64'hFFFF_FFFF - biased) biased = 64'hFFFF_FFFF;
         else biased = biased + {32'd0, size};
         cash = (prod > (cash ^ CASH_MIN)) ? CASH_MIN : cash - prod;
      end else begin
         if ({32'd0, size} > biased) biased = '0;
         else biased = biased - {32'd0, size};
         room = CASH_MAX - cash;
         cash = (prod > room) ? CASH_MAX : cash + prod;
      end
      position = biased[31:0] ^ POS_BIAS;
   endtask

   task automatic track_quotes(event_word_type w);
      int k;
      int s;
      k = 0;
      s = 2;
      case (w.opcode)
         OP_UPDATE: begin
            requote_side(0, w.bid_wanted, w.bid_px, w.bid_qty, w.bid_new_id, k);
            requote_side(1, w.ask_wanted, w.ask_px, w.ask_qty, w.ask_new_id, k);
         end
         OP_ACK: begin
            ack_side(0, w.ref_id, w.amount);
            ack_side(1, w.ref_id, w.amount);
         end
         OP_TRADE: begin
            // bid wins when both orders carry the id
            if (book_id[0] != 0 && w.ref_id == book_id[0]) s = 0;
            else if (book_id[1] != 0 && w.ref_id == book_id[1]) s = 1;
            if (s < 2) begin
               fill_side(s, w.amount, w.trade_price);
               post_action(KIND_FILL, s, w.ref_id, w.trade_price, w.amount);
               k = 1;
            end
         end
         default: ;
      endcase
      if (k > 0) actions_due[actions_due.size() - 1].last = 1'b1;
   endtask

   task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
         mismatches++;
      end
   endtask

   // predictor and scoreboard
   always @(posedge clock) begin
      action_word_type a;
      if (reset) begin
         for (int s = 0; s < 2; s++) begin
            book_id[s]      = '0;
            book_pending[s] = 1'b0;
            book_live[s]    = 1'b0;
            book_price[s]   = '0;
            book_qty[s]     = '0;
         end
         position = '0;
         cash     = '0;
      end else begin
         if (req_valid && req_bus.ready) begin
            track_quotes(req_word);
            case (req_word.opcode)
               OP_UPDATE: n_updates++;
               OP_ACK:    n_acks++;
               OP_TRADE:  n_trades++;
               default: ;
            endcase
         end
         if (rsp_bus.valid && rsp_ready) begin
            n_actions++;
            if (actions_due.size() == 0) begin
               $error("result word with nothing expected: kind %0d side %0d id 0x%0h",
                      rsp_bus.kind, rsp_bus.side, rsp_bus.ord_id);
               mismatches++;
            end else begin
               a = actions_due.pop_front();
               if (a.kind == KIND_FILL) n_fills++;
               check_field("kind", {62'd0, a.kind}, {62'd0, rsp_bus.kind});
               check_field("side", {63'd0, a.side}, {63'd0, rsp_bus.side});
               check_field("ord_id", {32'd0, a.ord_id}, {32'd0, rsp_bus.ord_id});
               check_field("price", {32'd0, a.price}, {32'd0, rsp_bus.price});
               check_field("quantity", {32'd0, a.quantity}, {32'd0, rsp_bus.quantity});
               check_field("inv_after", {32'd0, a.inventory},
                           {32'd0, rsp_bus.inv_after});
               check_field("cash_after", a.cash, {rsp_bus.cash_after});
               check_field("last", {63'd0, a.last}, {63'd0, rsp_bus.last});
            end
         end
      end
      req_taken <= req_valid && req_bus.ready;
   end

   function automatic logic sender_gap();
      case (gap_mode)
         GAP_SEND: return $urandom_range(99) < 85;
         GAP_BOTH: return $urandom_range(99) < 7;
         default:  return 1'b0;
      endcase
   endfunction

   function automatic logic receiver_ready();
      case (gap_mode)
         GAP_RECV: return $urandom_range(99) >= 85;
         GAP_BOTH: return $urandom_range(99) >= 7;
         default:  return 1'b1;
      endcase
   endfunction

   // driver: new word only once the held one has been taken
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         if (!req_valid || req_taken) begin
            if (pending_words.size() != 0 && !sender_gap()) begin
               req_word  <= pending_words.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_ready <= receiver_ready();
      end
   end

   function automatic event_word_type noise_word();
      event_word_type w;
      w.opcode      = 2'($urandom_range(3));
      w.bid_wanted  = 1'($urandom);
      w.bid_px      = $urandom;
      w.bid_qty     = $urandom;
      w.ask_wanted  = 1'($urandom);
      w.ask_px      = $urandom;
      w.ask_qty     = $urandom;
      w.ref_id      = $urandom;
      w.amount      = $urandom;
      w.trade_price = $urandom;
      w.bid_new_id  = $urandom;
      w.ask_new_id  = $urandom;
      return w;
   endfunction

   function automatic event_word_type mk_update(logic bw, logic [31:0] bp, logic [31:0] bq,
                                                logic [31:0] bid_id, logic aw, logic [31:0] ap,
                                                logic [31:0] aq, logic [31:0] ask_id);
      event_word_type w;
      w = noise_word();
      w.opcode     = OP_UPDATE;
      w.bid_wanted = bw;
      w.bid_px     = bp;
      w.bid_qty    = bq;
      w.bid_new_id = bid_id;
      w.ask_wanted = aw;
      w.ask_px     = ap;
      w.ask_qty    = aq;
      w.ask_new_id = ask_id;
      return w;
   endfunction

   function automatic event_word_type mk_ack(logic [31:0] id, logic [31:0] qty);
      event_word_type w;
      w = noise_word();
      w.opcode = OP_ACK;
      w.ref_id = id;
      w.amount = qty;
      return w;
   endfunction

   function automatic event_word_type mk_trade(logic [31:0] id, logic [31:0] size,
                                               logic [31:0] px);
      event_word_type w;
      w = noise_word();
      w.opcode      = OP_TRADE;
      w.ref_id      = id;
      w.amount      = size;
      w.trade_price = px;
      return w;
   endfunction

   function automatic logic [31:0] pick_qty();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 60) return $urandom_range(100, 1);
      if (r < 85) return $urandom_range(100000, 1);
      if (r < 95) return $urandom;
      return (r < 97) ? 32'd0 : 32'hFFFF_FFFF;
   endfunction

   function automatic logic [31:0] pick_price();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 70) return 32'd1000 + $urandom_range(50);
      if (r < 92) return $urandom;
      return (r < 96) ? 32'd0 : 32'hFFFF_FFFF;
   endfunction

   function automatic logic [31:0] pick_new_id();
      int unsigned r;
      logic [31:0] id;
      r = $urandom_range(99);
      if (r < 15) return $urandom_range(4, 1);
      if (r < 20) return 32'hFFFF_FFFF;
      id = $urandom;
      return (id == 0) ? 32'd1 : id;
   endfunction

   // mostly ids that are live or were just handed out, so acks and trades land
   function automatic logic [31:0] pick_ref();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 35) return book_id[$urandom_range(1)];
      if (r < 85 && recent_ids.size() != 0) return recent_ids[$urandom_range(recent_ids.size()-1)];
      if (r < 95) return $urandom;
      return 32'd0;
   endfunction

   task automatic make_random_word(inout logic [31:0] want_px [2],
                                   inout logic [31:0] want_qty [2],
                                   output event_word_type w);
      int unsigned r;
      int unsigned m;
      logic [31:0] ids [2];
      logic        wanted [2];
      r = $urandom_range(99);
      if (r < 42) begin
         for (int s = 0; s < 2; s++) begin
            m = $urandom_range(99);
            if (m >= 45 && m < 65) want_px[s] = pick_price();
            else if (m >= 65 && m < 85) want_qty[s] = pick_qty();
            else if (m >= 85) begin
               want_px[s]  = pick_price();
               want_qty[s] = pick_qty();
            end
            ids[s]    = pick_new_id();
            wanted[s] = $urandom_range(99) < 85;
            recent_ids.insert(recent_ids.size(), ids[s]);
            if (recent_ids.size() > 8) void'(recent_ids.pop_front());
         end
         w = mk_update(wanted[0], want_px[0], want_qty[0], ids[0],
                       wanted[1], want_px[1], want_qty[1], ids[1]);
      end else if (r < 70) begin
         w = mk_ack(pick_ref(), ($urandom_range(99) < 15) ? 32'd0 : pick_qty());
      end else if (r < 98) begin
         w = mk_trade(pick_ref(), pick_qty(), pick_price());
      end else begin
         w = noise_word();
         w.opcode = OP_UNUSED;
      end
   endtask

   initial begin
      event_word_type w;
      logic [31:0] want_px [2];
      logic [31:0] want_qty [2];
      int counted;

      want_px  = '{32'd1000, 32'd1010};
      want_qty = '{32'd10, 32'd10};
      counted  = 0;

      w = noise_word();
      w.opcode = OP_UNUSED;
      queue_word(w);
      queue_word(mk_update(1'b1, 32'd100, 32'd10, 32'd5,
                           1'b1, 32'd200, 32'd20, 32'd7));
      // both sides still waiting on acks
      queue_word(mk_update(1'b1, 32'd300, 32'd30, 32'd11,
                           1'b1, 32'd400, 32'd40, 32'd12));
      queue_word(mk_ack(32'd5, 32'd10));
      queue_word(mk_ack(32'd7, 32'd0));
      queue_word(mk_ack(32'd99, 32'd1));
      queue_word(mk_update(1'b1, 32'd100, 32'd10, 32'd13,
                           1'b1, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      queue_word(mk_ack(32'hFFFF_FFFF, 32'hFFFF_FFFF));
      queue_word(mk_update(1'b1, 32'd150, 32'd10, 32'd14,
                           1'b0, 32'd0, 32'd0, 32'd15));
      queue_word(mk_ack(32'd5, 32'd8));
      // fill against the cancelled ask id
      queue_word(mk_trade(32'hFFFF_FFFF, 32'd3, 32'd50));
      queue_word(mk_trade(32'd5, 32'd4, 32'd100));
      // oversized fills: rest clamps at zero, position and cash hit their rails
      queue_word(mk_trade(32'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      queue_word(mk_trade(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      queue_word(mk_trade(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      queue_word(mk_trade(32'd0, 32'd5, 32'd5));
      queue_word(mk_trade(32'd1234, 32'd5, 32'd5));
      // same id on both sides
      queue_word(mk_update(1'b1, 32'd500, 32'd50, 32'd3,
                           1'b1, 32'd600, 32'd60, 32'd3));
      queue_word(mk_ack(32'd3, 32'd5));
      queue_word(mk_trade(32'd3, 32'd1, 32'd1));
      queue_word(mk_update(1'b0, 32'd0, 32'd0, 32'd20,
                           1'b1, 32'd600, 32'd60, 32'd21));
      // zero id: accepted, never matched by a trade
      queue_word(mk_update(1'b1, 32'd700, 32'd70, 32'd0,
                           1'b1, 32'd800, 32'd80, 32'd22));
      queue_word(mk_ack(32'd0, 32'd6));
      queue_word(mk_trade(32'd0, 32'd1, 32'd1));

      repeat (10) @(negedge clock);
      reset <= 1'b0;

      while (counted < RANDOM_WORDS) begin
         @(posedge clock);
         #1;
         if (pending_words.size() == 0) begin
            gap_mode = gap_mode_type'((counted / SEGMENT_WORDS) % 4);
            make_random_word(want_px, want_qty, w);
            queue_word(w);
            if (w.opcode != OP_UNUSED) counted++;
         end
      end

      while (pending_words.size() != 0 || req_valid) begin
         @(posedge clock);
         #1;
      end
      gap_mode = GAP_NONE;
      while (actions_due.size() != 0) begin
         @(posedge clock);
         #1;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      #1;

      $display("covered %0d updates, %0d acks, %0d trades; %0d result words seen, %0d fills",
               n_updates, n_acks, n_trades, n_actions, n_fills);
      $display("idle phases: none, sender gaps, receiver stalls, light gaps on both sides");
      if (mismatches == 0) begin
         $display("two_sided_quote_order_tracker_core regression: pass");
      end else begin
         $display("two_sided_quote_order_tracker_core regression: fail");
      end
      $finish;
   end

endmodule

>>> two_sided_quote_order_tracker_core.f
hdl/tqot_pkg.sv
hdl/tqot_req_if.sv
hdl/tqot_rsp_if.sv
hdl/two_sided_quote_order_tracker_core.sv
dv/tb_two_sided_quote_order_tracker_core.sv
